// ===== rtl/core/ehcc_pkg.sv =====
// Edge histogram cell classifier: shared types, widths, type codes,
// register indexes and the per-lane filter coefficients.
// No dependencies.
`timescale 1ns / 1ps

package ehcc_pkg;

    localparam int PIX_W      = 8;
    localparam int NUM_PIX    = 4;
    localparam int NUM_DIR    = 5;
    localparam int RESP_W     = 20;   // |filter| * gain max 510000
    localparam int SQ_W       = 20;   // (4p - S)^2 max 585225
    localparam int VAR_W      = 22;   // sum of four squares
    localparam int THR_W      = 10;
    localparam int LIM_W      = 14;
    localparam int CNT_W      = 9;
    localparam int TYPE_W     = 3;
    localparam int GAIN_W     = 11;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 14;

    localparam int THR_SCALE   = 1000;
    localparam int LIM_SHIFT   = 6;    // variance * 64
    localparam int THR_RESET   = 11;
    localparam int LIM_RESET   = 15;

    localparam logic [TYPE_W-1:0] TYPE_VERT    = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_HORIZ   = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_DIAG45  = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_DIAG135 = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_NONDIR  = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_NONE    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLAT_VAR_LIMIT = 8'd1;

    typedef logic [PIX_W-1:0]                 pixel_t;
    typedef logic [NUM_PIX-1:0][PIX_W-1:0]    cell_t;   // [0] tl, [1] tr, [2] bl, [3] br
    typedef logic [RESP_W-1:0]                resp_t;
    typedef logic [CNT_W-1:0]                 count_t;

    // Pixel bit order in use_px / neg_px: 0 tl, 1 tr, 2 bl, 3 br
    typedef struct packed {
        logic [NUM_PIX-1:0] use_px;
        logic [NUM_PIX-1:0] neg_px;
        logic [GAIN_W-1:0]  gain;
    } lane_coef_t;

    localparam lane_coef_t LANE_COEF [NUM_DIR] = '{
        '{use_px: 4'b1111, neg_px: 4'b1010, gain: 11'd1000},  // vertical
        '{use_px: 4'b1111, neg_px: 4'b1100, gain: 11'd1000},  // horizontal
        '{use_px: 4'b1001, neg_px: 4'b1000, gain: 11'd1414},  // 45 degree
        '{use_px: 4'b0110, neg_px: 4'b0100, gain: 11'd1414},  // 135 degree
        '{use_px: 4'b1111, neg_px: 4'b0110, gain: 11'd1000}   // nondirectional
    };

    typedef struct packed {
        logic [TYPE_W-1:0]         edge_type;
        count_t [NUM_DIR-1:0]      counts;
        logic                      window_done;
    } result_t;

endpackage

// ===== rtl/core/ehcc_filter_lane.sv =====
// One directional filter lane: signed pixel sum, magnitude, scaled gain.
// Depends on ehcc_pkg.
`timescale 1ns / 1ps

module ehcc_filter_lane (
    input  logic                 aclk,
    input  logic                 adv,
    input  ehcc_pkg::cell_t      px,
    input  ehcc_pkg::lane_coef_t coef,
    output ehcc_pkg::resp_t      resp
);
    import ehcc_pkg::*;

    logic signed [10:0]          acc;
    logic [9:0]                  mag;
    logic [RESP_W+GAIN_W-11:0]   prod;
    resp_t                       resp_reg;
    resp_t                       resp_next;

    always_comb begin
        acc = '0;
        for (int i = 0; i < NUM_PIX; i++) begin
            if (coef.use_px[i]) begin
                if (coef.neg_px[i]) begin
                    acc = acc - $signed({3'b000, px[i]});
                end else begin
                    acc = acc + $signed({3'b000, px[i]});
                end
            end
        end
        mag       = acc[10] ? 10'(-acc) : acc[9:0];
        prod      = 21'({11'b0, mag} * {10'b0, coef.gain});
        resp_next = prod[RESP_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            resp_reg <= resp_next;
        end
    end

    assign resp = resp_reg;

endmodule

// ===== rtl/core/ehcc_var_unit.sv =====
// Variance lane: four squared deviations (4p - S)^2 of the cell, registered.
// Depends on ehcc_pkg.
`timescale 1ns / 1ps

module ehcc_var_unit (
    input  logic                          aclk,
    input  logic                          adv,
    input  ehcc_pkg::cell_t               px,
    output logic [ehcc_pkg::NUM_PIX-1:0][ehcc_pkg::SQ_W-1:0] sq
);
    import ehcc_pkg::*;

    logic [9:0]                        pix_sum;
    logic signed [10:0]                dev [NUM_PIX];
    logic signed [21:0]                dev_sq [NUM_PIX];
    logic [NUM_PIX-1:0][SQ_W-1:0]      sq_reg;
    logic [NUM_PIX-1:0][SQ_W-1:0]      sq_next;

    always_comb begin
        pix_sum = {2'b00, px[0]} + {2'b00, px[1]} + {2'b00, px[2]} + {2'b00, px[3]};
        for (int i = 0; i < NUM_PIX; i++) begin
            dev[i]     = $signed({1'b0, px[i], 2'b00}) - $signed({1'b0, pix_sum});
            dev_sq[i]  = dev[i] * dev[i];
            sq_next[i] = dev_sq[i][SQ_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg <= sq_next;
        end
    end

    assign sq = sq_reg;

endmodule

// ===== rtl/core/ehcc_merge.sv =====
// Merge stage: flatness test, largest-response pick, threshold test and
// the five saturating per-type window counters. Depends on ehcc_pkg.
`timescale 1ns / 1ps

module ehcc_merge #(
    parameter int unsigned COUNT_CAP = 256
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              adv,
    input  ehcc_pkg::resp_t [ehcc_pkg::NUM_DIR-1:0]           resp,
    input  logic [ehcc_pkg::NUM_PIX-1:0][ehcc_pkg::SQ_W-1:0]  sq,
    input  logic                                              last_in,
    input  logic [ehcc_pkg::RESP_W-1:0]                       thr_scaled,
    input  logic [ehcc_pkg::VAR_W-1:0]                        lim_scaled,
    output ehcc_pkg::result_t                                 result
);
    import ehcc_pkg::*;

    localparam count_t CAP_C = count_t'(COUNT_CAP);

    logic [VAR_W-1:0]       var_sum;
    logic                   flat;
    resp_t                  best;
    logic [TYPE_W-1:0]      best_idx;
    logic                   is_edge;
    logic [TYPE_W-1:0]      res_type;
    count_t [NUM_DIR-1:0]   cnt_reg;
    count_t [NUM_DIR-1:0]   cnt_upd;
    count_t [NUM_DIR-1:0]   cnt_next;
    result_t                result_reg;

    always_comb begin
        var_sum = '0;
        for (int i = 0; i < NUM_PIX; i++) begin
            var_sum = var_sum + {{(VAR_W-SQ_W){1'b0}}, sq[i]};
        end
        flat = var_sum < lim_scaled;

        // strict compare: first filter wins ties
        best     = '0;
        best_idx = TYPE_VERT;
        for (int i = 0; i < NUM_DIR; i++) begin
            if (best < resp[i]) begin
                best     = resp[i];
                best_idx = TYPE_W'(i);
            end
        end

        is_edge  = !flat && !(best < thr_scaled);
        res_type = is_edge ? best_idx : TYPE_NONE;

        for (int i = 0; i < NUM_DIR; i++) begin
            cnt_upd[i] = cnt_reg[i];
            if (is_edge && (best_idx == TYPE_W'(i)) && (cnt_reg[i] < CAP_C)) begin
                cnt_upd[i] = cnt_reg[i] + 1'b1;
            end
        end
        cnt_next = last_in ? '0 : cnt_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (adv) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            result_reg.edge_type   <= res_type;
            result_reg.counts      <= cnt_upd;
            result_reg.window_done <= last_in;
        end
    end

    assign result = result_reg;

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg[0] <= CAP_C) && (cnt_reg[1] <= CAP_C) && (cnt_reg[2] <= CAP_C) &&
        (cnt_reg[3] <= CAP_C) && (cnt_reg[4] <= CAP_C))
        else $error("window counter above cap");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && last_in |=> (cnt_reg == '0))
        else $error("counters not cleared after window end");

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(cnt_reg))
        else $error("counters moved without a transaction");

    a_none_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && (res_type == TYPE_NONE) && !last_in |=> $stable(cnt_reg))
        else $error("flat or weak cell changed a counter");

endmodule

// ===== rtl/core/edge_histogram_cell_classifier.sv =====
// Edge histogram cell classifier, top level.
// Depends on ehcc_pkg, ehcc_filter_lane, ehcc_var_unit, ehcc_merge.
//
// Usage:
//   s_ channel: one 2x2 grey cell per transaction, s_tlast marks the last
//   cell of a window. m_ channel: one result per cell with the edge type
//   and the five per-type counts of the window so far (this cell included);
//   m_tlast repeats s_tlast, the counts are then final and the counters
//   restart at zero for the next window.
//   cfg_ channel: register writes (0 edge threshold, 1 flat variance limit),
//   always ready; write only while no cell is in flight.
// Pipeline: an accepted cell is registered in the filter lanes, then in the
//   merge stage, whose register drives m_tdata with m_tvalid.
// Throughput: one cell per cycle unless m_tready stalls; the five filter
//   and variance lanes run in parallel; merge updates all counters at once.
// Reset (aresetn low, synchronous): pipeline empties, counters clear,
//   threshold returns to 11, flat variance limit to 15.
// Stall: with m_tready low the result holds; one more cell can sit in the
//   lane stage, after which s_tready drops until the result is taken.
`timescale 1ns / 1ps

module edge_histogram_cell_classifier #(
    parameter int unsigned MAX_CELLS  = 256,
    parameter int unsigned PIXEL_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right
    input  logic [31:0]                         s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // edge_type, count_vertical, count_horizontal, count_diag45,
    // count_diag135, count_nondirectional
    output logic [47:0]                         m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ehcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ehcc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ehcc_pkg::*;

    localparam int unsigned CNT_MAX   = (1 << CNT_W) - 1;
    localparam int unsigned COUNT_CAP = (MAX_CELLS < CNT_MAX) ? MAX_CELLS : CNT_MAX;
    localparam pixel_t PIX_MASK = (PIXEL_BITS >= PIX_W) ? {PIX_W{1'b1}} :
                                  PIX_W'((1 << PIXEL_BITS) - 1);

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic                       s1_last_reg;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic                       out_ready;
    logic                       s_fire;
    logic                       adv2;
    cell_t                      cell_in;
    resp_t [NUM_DIR-1:0]        resp;
    logic [NUM_PIX-1:0][SQ_W-1:0] sq;
    logic [RESP_W-1:0]          thr_scaled_reg;
    logic [VAR_W-1:0]           lim_scaled_reg;
    result_t                    result;

    assign out_ready = !m_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || out_ready;
    assign s_fire    = s_tvalid && s_tready;
    assign adv2      = s1_valid_reg && out_ready;

    always_comb begin
        for (int i = 0; i < NUM_PIX; i++) begin
            cell_in[i] = s_tdata[i*PIX_W +: PIX_W] & PIX_MASK;
        end
        s1_valid_next = s_tready ? s_tvalid : s1_valid_reg;
        m_valid_next  = out_ready ? s1_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_last_reg <= s_tlast;
        end
    end

    // registers held pre-scaled for the merge compares
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_scaled_reg <= RESP_W'(THR_RESET * THR_SCALE);
            lim_scaled_reg <= VAR_W'(LIM_RESET << LIM_SHIFT);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_EDGE_THRESHOLD: begin
                    thr_scaled_reg <= RESP_W'({{(RESP_W-THR_W){1'b0}}, cfg_data[THR_W-1:0]}
                                              * RESP_W'(THR_SCALE));
                end
                REG_FLAT_VAR_LIMIT: begin
                    lim_scaled_reg <= {{(VAR_W-LIM_W-LIM_SHIFT){1'b0}}, cfg_data[LIM_W-1:0],
                                       {LIM_SHIFT{1'b0}}};
                end
                default: begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < NUM_DIR; g++) begin : g_lane
        ehcc_filter_lane u_lane (
            .aclk (aclk),
            .adv  (s_fire),
            .px   (cell_in),
            .coef (LANE_COEF[g]),
            .resp (resp[g])
        );
    end

    ehcc_var_unit u_var (
        .aclk (aclk),
        .adv  (s_fire),
        .px   (cell_in),
        .sq   (sq)
    );

    ehcc_merge #(
        .COUNT_CAP (COUNT_CAP)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv2),
        .resp       (resp),
        .sq         (sq),
        .last_in    (s1_last_reg),
        .thr_scaled (thr_scaled_reg),
        .lim_scaled (lim_scaled_reg),
        .result     (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {result.counts, result.edge_type};
    assign m_tlast  = result.window_done;

endmodule

// ===== dv/ehcc_checker.sv =====
// Scoreboard for the edge histogram cell classifier: watches the cell, result
// and register-write channels, predicts each result and compares it.
// Depends on ehcc_pkg.
`timescale 1ns / 1ps

module ehcc_histogram_checker #(
    parameter int unsigned MAX_CELLS = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [31:0]                     s_tdata,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [47:0]                     m_tdata,
    input  logic                            m_tlast,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [ehcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ehcc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              pending,
    output int                              results_checked,
    output int                              windows_closed,
    output int                              edge_cells,
    output int                              capped_cells
);
    import ehcc_pkg::*;

    localparam int COUNT_CAP  = (MAX_CELLS < (2**CNT_W - 1)) ? MAX_CELLS : (2**CNT_W - 1);
    localparam int RESP_SCALE = 1000;
    localparam int DIAG_GAIN  = 1414;
    localparam int VAR_SCALE  = 64;   // 4p - S deviations carry a factor 16, four terms

    localparam logic [TYPE_W-1:0] DIR_CODE [NUM_DIR] = '{
        TYPE_VERT, TYPE_HORIZ, TYPE_DIAG45, TYPE_DIAG135, TYPE_NONDIR
    };

    typedef struct packed {
        logic [TYPE_W-1:0]    edge_type;
        count_t [NUM_DIR-1:0] counts;
        logic                 done;
    } cell_result_t;

    cell_result_t     expected_results [$];
    count_t           window_counts [NUM_DIR];
    logic [THR_W-1:0] edge_thr;
    logic [LIM_W-1:0] flat_limit;
    int               fail_count = 0;
    int               n_results  = 0;
    int               n_windows  = 0;
    int               n_edges    = 0;
    int               n_capped   = 0;

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Index of the winning direction, or NUM_DIR for a flat or weak cell.
    function automatic int strongest_direction(input cell_t px, input int thr, input int lim);
        int p [NUM_PIX];
        int score [NUM_DIR];
        int sum;
        int spread;
        int dev;
        int peak;
        int dir;
        int i;
        sum = 0;
        spread = 0;
        for (i = 0; i < NUM_PIX; i++) begin
            p[i] = px[i];
            sum += p[i];
        end
        for (i = 0; i < NUM_PIX; i++) begin
            dev = 4 * p[i] - sum;
            spread += dev * dev;
        end
        if (spread < VAR_SCALE * lim)
            return NUM_DIR;
        score[0] = mag(p[0] - p[1] + p[2] - p[3]) * RESP_SCALE;
        score[1] = mag(p[0] + p[1] - p[2] - p[3]) * RESP_SCALE;
        score[2] = mag(p[0] - p[3]) * DIAG_GAIN;
        score[3] = mag(p[1] - p[2]) * DIAG_GAIN;
        score[4] = mag(p[0] - p[1] - p[2] + p[3]) * RESP_SCALE;
        peak = 0;
        dir = 0;
        // strict compare: the earlier filter keeps a tie
        for (i = 0; i < NUM_DIR; i++) begin
            if (score[i] > peak) begin
                peak = score[i];
                dir = i;
            end
        end
        if (peak < thr * RESP_SCALE)
            return NUM_DIR;
        return dir;
    endfunction

    task automatic check_field(input string what, input int want, input int seen);
        if (want != seen) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: result %0d %s mismatch: expected %0d, got %0d",
                         $time, n_results, what, want, seen);
        end
    endtask

    always @(posedge aclk) begin : watch
        cell_result_t want;
        cell_result_t seen;
        int           dir;
        int           i;
        if (!aresetn) begin
            edge_thr = THR_W'(THR_RESET);
            flat_limit = LIM_W'(LIM_RESET);
            for (i = 0; i < NUM_DIR; i++)
                window_counts[i] = '0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                seen.edge_type = m_tdata[TYPE_W-1:0];
                for (i = 0; i < NUM_DIR; i++)
                    seen.counts[i] = m_tdata[TYPE_W + i*CNT_W +: CNT_W];
                seen.done = m_tlast;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result %0d arrived with nothing expected (type %0d)",
                                 $time, n_results, seen.edge_type);
                end else begin
                    want = expected_results.pop_front();
                    check_field("edge_type", want.edge_type, seen.edge_type);
                    for (i = 0; i < NUM_DIR; i++)
                        check_field($sformatf("count[%0d]", i), want.counts[i], seen.counts[i]);
                    check_field("window_done", want.done, seen.done);
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_EDGE_THRESHOLD)
                    edge_thr = cfg_data[THR_W-1:0];
                else if (cfg_index == REG_FLAT_VAR_LIMIT)
                    flat_limit = cfg_data[LIM_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                dir = strongest_direction(s_tdata, edge_thr, flat_limit);
                if (dir < NUM_DIR) begin
                    n_edges++;
                    if (window_counts[dir] < COUNT_CAP)
                        window_counts[dir]++;
                    else
                        n_capped++;
                end
                want.edge_type = (dir < NUM_DIR) ? DIR_CODE[dir] : TYPE_NONE;
                for (i = 0; i < NUM_DIR; i++)
                    want.counts[i] = window_counts[i];
                want.done = s_tlast;
                expected_results.push_back(want);
                if (s_tlast) begin
                    n_windows++;
                    for (i = 0; i < NUM_DIR; i++)
                        window_counts[i] = '0;
                end
            end
        end
        pending         <= expected_results.size();
        mismatches      <= fail_count;
        results_checked <= n_results;
        windows_closed  <= n_windows;
        edge_cells      <= n_edges;
        capped_cells    <= n_capped;
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the edge histogram cell classifier: clock, reset, cell
// stimulus, register writes and random backpressure; verdict at the end.
// Depends on ehcc_pkg, edge_histogram_cell_classifier, ehcc_histogram_checker.
`timescale 1ns / 1ps

module tb;
    import ehcc_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_MAX_CELLS  = 256;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 35;
    localparam int SAT_ITEMS    = N_MAX_CELLS + 6;
    localparam int SAT_PHASE    = 4;
    localparam int THR_MAX      = 2**THR_W - 1;
    localparam int LIM_MAX      = 2**LIM_W - 1;
    localparam int DATA_MAX     = 2**CFG_DATA_W - 1;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = '1;

    typedef enum {
        PAT_VERT, PAT_HORIZ, PAT_DIAG45, PAT_DIAG135, PAT_NONDIR, PAT_NOISE, PAT_NEAR_FLAT
    } cell_pattern_e;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;     // tl [7:0], tr [15:8], bl [23:16], br [31:24]
    logic                  s_tlast;     // last_cell
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [47:0]           m_tdata;     // edge_type, count_vertical .. count_nondirectional
    logic                  m_tlast;     // window_done
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int pending;
    int results_checked;
    int windows_closed;
    int edge_cells;
    int capped_cells;
    int cycles     = 0;
    int reg_writes = 0;
    int stall_left = 0;
    bit idle_on    = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    edge_histogram_cell_classifier #(
        .MAX_CELLS  (N_MAX_CELLS),
        .PIXEL_BITS (PIX_W)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ehcc_histogram_checker #(
        .MAX_CELLS (N_MAX_CELLS)
    ) histogram_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .windows_closed  (windows_closed),
        .edge_cells      (edge_cells),
        .capped_cells    (capped_cells)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result-side backpressure in random-length bursts while idle_on is set
    always @(negedge aclk) begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 11);
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            m_tready = 1'b1;
        end
    end

    function automatic pixel_t clip_pixel(input int v);
        return pixel_t'((v < 0) ? 0 : (v > 255) ? 255 : v);
    endfunction

    function automatic cell_t mk_cell(input int tl, input int tr, input int bl, input int br);
        cell_t c;
        c[0] = clip_pixel(tl);
        c[1] = clip_pixel(tr);
        c[2] = clip_pixel(bl);
        c[3] = clip_pixel(br);
        return c;
    endfunction

    // Half shaped edges with jitter, some raw noise, some nearly uniform cells.
    function automatic cell_t random_cell();
        cell_pattern_e pat;
        int            a;
        int            b;
        int            mid;
        int            px [NUM_PIX];
        int            i;
        cell_t         c;
        case ($urandom_range(0, 9))
            0:       pat = PAT_VERT;
            1:       pat = PAT_HORIZ;
            2:       pat = PAT_DIAG45;
            3:       pat = PAT_DIAG135;
            4:       pat = PAT_NONDIR;
            5, 6:    pat = PAT_NOISE;
            default: pat = PAT_NEAR_FLAT;
        endcase
        a = $urandom_range(0, 255);
        b = $urandom_range(0, 1) ? int'($urandom_range(0, 255))
                                 : a + int'($urandom_range(0, 40)) - 20;
        mid = (a + b) / 2;
        case (pat)
            PAT_VERT:    px = '{a, b, a, b};
            PAT_HORIZ:   px = '{a, a, b, b};
            PAT_DIAG45:  px = '{a, mid, mid, b};
            PAT_DIAG135: px = '{mid, a, b, mid};
            PAT_NONDIR:  px = '{a, b, b, a};
            PAT_NOISE:   px = '{$urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(0, 255), $urandom_range(0, 255)};
            default:     px = '{a, a, a, a};
        endcase
        for (i = 0; i < NUM_PIX; i++)
            c[i] = clip_pixel(px[i] + int'($urandom_range(0, 6)) - 3);
        return c;
    endfunction

    task automatic send_cell(input cell_t c, input logic last);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = c;
        s_tlast = last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Only called with no cell in flight.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = CFG_DATA_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        reg_writes++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int ph;
        int n;
        int a;
        int b;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed cells at reset settings: flat extremes, each direction, ties
        idle_on = 1'b1;
        send_cell(mk_cell(0, 0, 0, 0), 1'b0);
        send_cell(mk_cell(255, 255, 255, 255), 1'b0);
        send_cell(mk_cell(255, 0, 255, 0), 1'b0);
        send_cell(mk_cell(255, 255, 0, 0), 1'b0);
        send_cell(mk_cell(255, 128, 128, 0), 1'b0);
        send_cell(mk_cell(128, 255, 0, 128), 1'b0);
        send_cell(mk_cell(255, 0, 0, 255), 1'b0);
        send_cell(mk_cell(200, 100, 150, 150), 1'b0);   // vertical ties nondirectional
        send_cell(mk_cell(200, 150, 100, 150), 1'b0);   // horizontal ties nondirectional
        send_cell(mk_cell(200, 0, 200, 0), 1'b1);       // equal diagonals, vertical wins
        drain();

        // Largest response just under and exactly at the threshold
        write_reg(REG_EDGE_THRESHOLD, 20);
        write_reg(REG_FLAT_VAR_LIMIT, 1);
        send_cell(mk_cell(9, 0, 9, 0), 1'b0);
        send_cell(mk_cell(10, 0, 10, 0), 1'b0);
        drain();

        // Variance just under and exactly at the flat limit
        write_reg(REG_EDGE_THRESHOLD, 0);
        send_cell(mk_cell(1, 0, 1, 0), 1'b0);
        send_cell(mk_cell(2, 0, 2, 0), 1'b0);
        drain();

        // No flat cells and zero threshold: uniform cells come out vertical
        write_reg(REG_FLAT_VAR_LIMIT, 0);
        send_cell(mk_cell(0, 0, 0, 0), 1'b0);
        send_cell(mk_cell(128, 128, 128, 128), 1'b1);
        drain();

        // Write to an unmapped index must not disturb either register
        write_reg(REG_UNMAPPED, DATA_MAX);
        send_cell(mk_cell(0, 0, 0, 0), 1'b0);
        drain();

        // Upper data bits are dropped for the threshold: all ones means max threshold
        write_reg(REG_EDGE_THRESHOLD, DATA_MAX);
        send_cell(mk_cell(255, 0, 255, 0), 1'b1);
        drain();

        for (ph = 0; ph < PHASES; ph++) begin
            idle_on = (ph < PHASES - 2) && (ph != 3);
            if (ph == SAT_PHASE) begin
                // One long window of vertical cells to push a count into its cap
                write_reg(REG_EDGE_THRESHOLD, 0);
                write_reg(REG_FLAT_VAR_LIMIT, 0);
                for (n = 0; n < SAT_ITEMS; n++) begin
                    a = $urandom_range(0, 255);
                    b = $urandom_range(0, 255);
                    send_cell(mk_cell(a, b, a, b), n == SAT_ITEMS - 1);
                end
                drain();
            end
            case (ph)
                0: begin
                    write_reg(REG_EDGE_THRESHOLD, THR_RESET);
                    write_reg(REG_FLAT_VAR_LIMIT, LIM_RESET);
                end
                1: begin
                    write_reg(REG_EDGE_THRESHOLD, 0);
                    write_reg(REG_FLAT_VAR_LIMIT, 0);
                end
                2: begin
                    write_reg(REG_EDGE_THRESHOLD, THR_MAX);
                    write_reg(REG_FLAT_VAR_LIMIT, 0);
                end
                3: begin
                    write_reg(REG_EDGE_THRESHOLD, 0);
                    write_reg(REG_FLAT_VAR_LIMIT, LIM_MAX);
                end
                PHASES - 1: begin
                    write_reg(REG_EDGE_THRESHOLD, $urandom_range(0, DATA_MAX));
                    write_reg(REG_FLAT_VAR_LIMIT, $urandom_range(0, DATA_MAX));
                end
                default: begin
                    write_reg(REG_EDGE_THRESHOLD, $urandom_range(0, 60));
                    write_reg(REG_FLAT_VAR_LIMIT, $urandom_range(0, 400));
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                send_cell(random_cell(), $urandom_range(0, 11) == 0);
            drain();
        end

        repeat (8) @(posedge aclk);
        $display("Run covered %0d cell results in %0d windows: %0d edge cells, %0d at the cap.",
                 results_checked, windows_closed, edge_cells, capped_cells);
        $display("%0d register writes over threshold and flat-limit extremes; %0d mismatches.",
                 reg_writes, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
